>>> src/modbus_rtu_answer_checker_unit_defines.svh
// Assertion macros shared by the checker RTL.
// Each macro expects clk and rst_n in scope.
`ifndef MODBUS_RTU_ANSWER_CHECKER_UNIT_DEFINES_SVH
`define MODBUS_RTU_ANSWER_CHECKER_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MRAC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MRAC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/mrac_pkg.sv
`default_nettype none

package mrac_pkg;

    localparam int MAX_FRAME_DEF = 256;

    localparam int BYTE_W   = 8;
    localparam int CRC_W    = 16;
    localparam int LEN_W    = 9;
    localparam int ERR_W    = 16;
    localparam int STAT_W   = 2;
    localparam int REG_W    = 32;
    localparam int ADDR_W   = 3;

    localparam logic [CRC_W-1:0] CRC_SEED = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;
    localparam logic [REG_W-1:0] SUPPORTED_RESET = 32'd98430;

    localparam logic [STAT_W-1:0] ST_OK          = 2'd0;
    localparam logic [STAT_W-1:0] ST_CRC_BAD     = 2'd1;
    localparam logic [STAT_W-1:0] ST_EXCEPTION   = 2'd2;
    localparam logic [STAT_W-1:0] ST_UNSUPPORTED = 2'd3;

    // Register index taken from paddr[2]
    localparam logic REG_SUPPORTED_CODES = 1'b0;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
        logic              last;
    } in_word_t;

    // Reflected CRC-16 over one byte, eight unrolled shift steps
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] acc,
                                                   input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        logic             lsb;
        c = acc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
        for (int k = 0; k < BYTE_W; k++)
        begin
            lsb = c[0];
            c   = c >> 1;
            if (lsb)
            begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> src/mrac_apb_regs.sv
`default_nettype none

module mrac_apb_regs (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [mrac_pkg::ADDR_W-1:0] paddr,
    input  wire logic [mrac_pkg::REG_W-1:0]  pwdata,
    output logic      [mrac_pkg::REG_W-1:0]  prdata,
    output logic                            pready,
    output logic      [mrac_pkg::REG_W-1:0]  supported_codes
);
    import mrac_pkg::*;

    logic [REG_W-1:0] supported_reg;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            supported_reg <= SUPPORTED_RESET;
        end
        else if (wr_en && (paddr[2] == REG_SUPPORTED_CODES))
        begin
            supported_reg <= pwdata;
        end
    end

    // Low address bits select the byte lane only; ignore them
    assign prdata = (paddr[2] == REG_SUPPORTED_CODES) ? supported_reg : '0;
    assign supported_codes = supported_reg;

endmodule

`default_nettype wire

>>> src/mrac_in_stage.sv
`default_nettype none

module mrac_in_stage (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        byte_valid,
    output logic                             byte_stall,
    input  wire logic [mrac_pkg::BYTE_W-1:0] data_byte,
    input  wire logic                        last_byte,
    input  wire logic                        consume,
    output mrac_pkg::in_word_t               word
);
    import mrac_pkg::*;

    logic              valid_reg;
    logic [BYTE_W-1:0] data_reg;
    logic              last_reg;

    // Hold the word while the core cannot take it
    assign byte_stall = valid_reg && !consume;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!byte_stall)
        begin
            valid_reg <= byte_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && !byte_stall)
        begin
            data_reg <= data_byte;
            last_reg <= last_byte;
        end
    end

    assign word.valid = valid_reg;
    assign word.data  = data_reg;
    assign word.last  = last_reg;

endmodule

`default_nettype wire

>>> src/mrac_frame_core.sv
`default_nettype none
`include "modbus_rtu_answer_checker_unit_defines.svh"

module mrac_frame_core #(
    parameter int MAX_FRAME = mrac_pkg::MAX_FRAME_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire mrac_pkg::in_word_t          word,
    output logic                             consume,
    input  wire logic [mrac_pkg::REG_W-1:0]  supported_codes,
    output logic                             status_valid,
    input  wire logic                        status_stall,
    output logic      [mrac_pkg::STAT_W-1:0] status,
    output logic      [mrac_pkg::BYTE_W-1:0] function_code,
    output logic      [mrac_pkg::LEN_W-1:0]  frame_length,
    output logic      [mrac_pkg::ERR_W-1:0]  error_total
);
    import mrac_pkg::*;

    localparam int CNT_W = $clog2(MAX_FRAME + 1);

    logic [CRC_W-1:0]  crc_reg,   crc_next;
    logic [BYTE_W-1:0] held0_reg, held0_next;
    logic [BYTE_W-1:0] held1_reg, held1_next;
    logic [CNT_W-1:0]  cnt_reg,   cnt_next;
    logic [BYTE_W-1:0] func_reg,  func_next;
    logic [ERR_W-1:0]  err_reg,   err_next;

    logic [CRC_W-1:0]  crc_upd;
    logic [CNT_W-1:0]  cnt_upd;
    logic [BYTE_W-1:0] func_upd;
    logic [STAT_W-1:0] stat_calc;
    logic              out_free;
    logic              finish;

    logic              out_valid_reg;
    logic [STAT_W-1:0] out_stat_reg;
    logic [BYTE_W-1:0] out_func_reg;
    logic [LEN_W-1:0]  out_len_reg;
    logic [ERR_W-1:0]  out_err_reg;

    assign out_free = !out_valid_reg || !status_stall;
    assign consume  = word.valid && (!word.last || out_free);
    assign finish   = consume && word.last;

    always_comb
    begin
        crc_upd  = (cnt_reg >= CNT_W'(2)) ? crc_byte(crc_reg, held0_reg) : crc_reg;
        func_upd = (cnt_reg == CNT_W'(1)) ? word.data : func_reg;
        cnt_upd  = (cnt_reg < CNT_W'(MAX_FRAME)) ? (cnt_reg + CNT_W'(1)) : cnt_reg;

        // Check order: minimum length and CRC, exception flag, code range and supported mask
        if ((cnt_upd < CNT_W'(4)) || (crc_upd[7:0] != held1_reg)
            || (crc_upd[15:8] != word.data))
        begin
            stat_calc = ST_CRC_BAD;
        end
        else if (func_upd[7])
        begin
            stat_calc = ST_EXCEPTION;
        end
        else if ((func_upd[7:5] != 3'd0) || !supported_codes[func_upd[4:0]])
        begin
            stat_calc = ST_UNSUPPORTED;
        end
        else
        begin
            stat_calc = ST_OK;
        end

        crc_next   = crc_reg;
        held0_next = held0_reg;
        held1_next = held1_reg;
        cnt_next   = cnt_reg;
        func_next  = func_reg;
        err_next   = err_reg;
        if (consume)
        begin
            if (word.last)
            begin
                crc_next   = CRC_SEED;
                held0_next = '0;
                held1_next = '0;
                cnt_next   = '0;
                func_next  = '0;
                if (stat_calc != ST_OK)
                begin
                    err_next = err_reg + ERR_W'(1);
                end
            end
            else
            begin
                crc_next   = crc_upd;
                held0_next = held1_reg;
                held1_next = word.data;
                cnt_next   = cnt_upd;
                func_next  = func_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg       <= CRC_SEED;
            held0_reg     <= '0;
            held1_reg     <= '0;
            cnt_reg       <= '0;
            func_reg      <= '0;
            err_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            crc_reg   <= crc_next;
            held0_reg <= held0_next;
            held1_reg <= held1_next;
            cnt_reg   <= cnt_next;
            func_reg  <= func_next;
            err_reg   <= err_next;
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!status_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            out_stat_reg <= stat_calc;
            out_func_reg <= func_upd;
            out_len_reg  <= LEN_W'(cnt_upd);
            out_err_reg  <= err_next;
        end
    end

    assign status_valid  = out_valid_reg;
    assign status        = out_stat_reg;
    assign function_code = out_func_reg;
    assign frame_length  = out_len_reg;
    assign error_total   = out_err_reg;

    `MRAC_ASSERT_NEXT(a_final_shows_result, finish, status_valid, "final byte lost its result")
    `MRAC_ASSERT_NEXT(a_frame_state_cleared, finish,
        (cnt_reg == '0) && (crc_reg == CRC_SEED), "frame state not cleared")
    `MRAC_ASSERT_NEXT(a_err_only_on_finish, !finish, $stable(err_reg),
        "error count moved without a frame end")
    `MRAC_ASSERT_NOW(a_short_frame_bad, status_valid && (frame_length < LEN_W'(4)),
        status == ST_CRC_BAD, "short frame not flagged")

endmodule

`default_nettype wire

>>> src/modbus_rtu_answer_checker_unit.sv
// A final byte passes the input register, then the status registers.
// Throughput: one byte per cycle unless a held status stalls a final byte,
// set by the unrolled CRC byte network between input and frame state registers.
// Reset: rst_n clears asynchronously; CRC returns to its seed, counts and
// the error total to zero, the supported-code mask to its default.
`default_nettype none

module modbus_rtu_answer_checker_unit #(
    parameter int MAX_FRAME = mrac_pkg::MAX_FRAME_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [mrac_pkg::ADDR_W-1:0] paddr,
    input  wire logic [mrac_pkg::REG_W-1:0]  pwdata,
    output logic      [mrac_pkg::REG_W-1:0]  prdata,
    output logic                             pready,
    input  wire logic                        byte_valid,
    output logic                             byte_stall,
    input  wire logic [mrac_pkg::BYTE_W-1:0] data_byte,
    input  wire logic                        last_byte,
    output logic                             status_valid,
    input  wire logic                        status_stall,
    output logic      [mrac_pkg::STAT_W-1:0] status,
    output logic      [mrac_pkg::BYTE_W-1:0] function_code,
    output logic      [mrac_pkg::LEN_W-1:0]  frame_length,
    output logic      [mrac_pkg::ERR_W-1:0]  error_total
);
    import mrac_pkg::*;

    logic [REG_W-1:0] supported_codes;
    in_word_t         word;
    logic             consume;

    mrac_apb_regs u_regs (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .supported_codes (supported_codes)
    );

    mrac_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .consume    (consume),
        .word       (word)
    );

    mrac_frame_core #(
        .MAX_FRAME (MAX_FRAME)
    ) u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .word            (word),
        .consume         (consume),
        .supported_codes (supported_codes),
        .status_valid    (status_valid),
        .status_stall    (status_stall),
        .status          (status),
        .function_code   (function_code),
        .frame_length    (frame_length),
        .error_total     (error_total)
    );

endmodule

`default_nettype wire
